>>> hw/rtl/lbs_pkg.sv
// Shared constants, widths and types for the linear blend skinning block.
// Used by every module under hw/rtl except lbs_ram; depends on nothing else.
`timescale 1ns / 1ps

package lbs_pkg;

    localparam int MAX_BONES_DEF  = 64;
    localparam int INFLUENCES_DEF = 4;
    localparam int MAX_INFL       = 4;
    localparam int WORDS_PER_BONE = 12;
    localparam int AXES           = 3;

    // Field widths
    localparam int POS_W  = 32;
    localparam int NRM_W  = 16;
    localparam int WGT_W  = 16;
    localparam int BONE_W = 8;
    localparam int SLOT_W = 10;
    localparam int ELEM_W = 4;
    localparam int CFG_W  = 7;

    // Slot to bone split: bone = (slot * 2731) >> 15, exact for every 10-bit slot
    localparam int SLOT_RECIP  = 2731;
    localparam int SLOT_RSH    = 15;
    localparam int SLOT_PROD_W = SLOT_W + 12;

    // Datapath widths
    localparam int PP_W   = 64;   // matrix word times position
    localparam int PN_W   = 48;   // matrix word times normal
    localparam int T_W    = 50;   // transformed position / summed normal products
    localparam int Q_W    = 36;   // rotated normal after rounding
    localparam int TW_W   = 66;   // position times weight
    localparam int QW_W   = 52;   // normal times weight
    localparam int RT_W   = 51;
    localparam int RQ_W   = 37;
    localparam int ACCP_W = 53;
    localparam int ACCN_W = 39;
    localparam int MAG_W  = 39;
    localparam int HI_W   = 6;    // bit index into a magnitude
    localparam int NMAG_W = 30;   // scaled magnitude, largest in [2^28, 2^30)
    localparam int SQP_W  = 60;
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 32;
    localparam int QUO_W  = 15;
    localparam int NSH    = 14;   // Q2.14 scale of the output normal

    localparam int SQRT_STEPS = 32;
    localparam int SQRT_ACC_W = 63;
    localparam int DIV_REM_W  = 46;

    localparam logic signed [ACCP_W-1:0] POS_MAX = ACCP_W'(64'sd2147483647);
    localparam logic signed [ACCP_W-1:0] POS_MIN = -POS_MAX - ACCP_W'(64'sd1);

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_BONES_IN_USE = PADDR_W'(0);

    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctl_t;

endpackage

>>> hw/rtl/lbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module lbs_ram #(
    parameter int Width = 32,
    parameter int Depth = 64,
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [Width-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lbs_blend.sv
// Matrix store (one bank set per influence) and the per-influence transform and
// weighted accumulation, stages 1 to 6. Depends on lbs_pkg and lbs_ram.
`timescale 1ns / 1ps

module lbs_blend import lbs_pkg::*; #(
    parameter int MAX_BONES  = MAX_BONES_DEF,
    parameter int INFLUENCES = INFLUENCES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     ld_we,
    input  logic [SLOT_W-1:0]        ld_slot,
    input  logic signed [POS_W-1:0]  ld_value,
    input  logic                     vtx_valid,
    input  logic signed [POS_W-1:0]  vtx_pos [AXES],
    input  logic signed [NRM_W-1:0]  vtx_nrm [AXES],
    input  logic [MAX_INFL*BONE_W-1:0] vtx_bones,
    input  logic [MAX_INFL*WGT_W-1:0]  vtx_weights,
    input  logic                     vtx_last,
    input  logic [CFG_W-1:0]         bones_in_use,
    output beat_ctl_t                out_ctl,
    output logic signed [ACCP_W-1:0] accp [AXES],
    output logic signed [ACCN_W-1:0] accn [AXES]
);

    localparam int AW          = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int STORE_DEPTH = MAX_BONES * WORDS_PER_BONE;

    // Load decode
    logic [SLOT_PROD_W-1:0] slot_prod;
    logic [BONE_W-1:0]      ld_bone;
    logic [SLOT_W-1:0]      bone_base;
    logic [ELEM_W-1:0]      ld_elem;
    logic                   ld_ok;

    assign slot_prod = SLOT_PROD_W'(ld_slot) * SLOT_PROD_W'(SLOT_RECIP);
    assign ld_bone   = BONE_W'(slot_prod >> SLOT_RSH);
    assign bone_base = SLOT_W'(({2'b00, ld_bone} << 3) + ({2'b00, ld_bone} << 2));
    assign ld_elem   = ELEM_W'(ld_slot - bone_base);
    assign ld_ok     = ld_we && (int'(ld_slot) < STORE_DEPTH);

    // Influence select
    logic [BONE_W:0]         lim;
    logic [BONE_W-1:0]       bsel   [INFLUENCES];
    logic [WGT_W-1:0]        wsel   [INFLUENCES];
    logic                    usable [INFLUENCES];
    logic [POS_W-1:0]        mq     [INFLUENCES][WORDS_PER_BONE];

    assign lim = ((BONE_W+1)'(bones_in_use) < (BONE_W+1)'(MAX_BONES)) ?
                 (BONE_W+1)'(bones_in_use) : (BONE_W+1)'(MAX_BONES);

    always_comb begin
        for (int j = 0; j < INFLUENCES; j++) begin
            bsel[j]   = vtx_bones[BONE_W*j +: BONE_W];
            wsel[j]   = vtx_weights[WGT_W*j +: WGT_W];
            usable[j] = !wsel[j][WGT_W-1] && (wsel[j] != '0) && ({1'b0, bsel[j]} < lim);
        end
    end

    for (genvar j = 0; j < INFLUENCES; j++) begin : g_infl
        for (genvar e = 0; e < WORDS_PER_BONE; e++) begin : g_word
            lbs_ram #(.Width(POS_W), .Depth(MAX_BONES)) u_ram (
                .aclk  (aclk),
                .we    (ld_ok && (ld_elem == ELEM_W'(e))),
                .waddr (ld_bone[AW-1:0]),
                .wdata (ld_value),
                .re    (en),
                .raddr (bsel[j][AW-1:0]),
                .rdata (mq[j][e])
            );
        end
    end

    // Stage 1: inputs beside the registered RAM data
    logic                    v1_reg, last1_reg;
    logic signed [POS_W-1:0] pos1_reg [AXES];
    logic signed [NRM_W-1:0] nrm1_reg [AXES];
    logic signed [WGT_W-1:0] wt1_reg  [INFLUENCES];
    logic                    use1_reg [INFLUENCES];

    // Stage 2: products
    logic                    v2_reg, last2_reg;
    logic signed [PP_W-1:0]  pp2_reg [INFLUENCES][AXES][AXES];
    logic signed [PN_W-1:0]  pn2_reg [INFLUENCES][AXES][AXES];
    logic signed [POS_W-1:0] tr2_reg [INFLUENCES][AXES];
    logic signed [WGT_W-1:0] wt2_reg [INFLUENCES];

    // Stage 3: row sums
    logic                    v3_reg, last3_reg;
    logic signed [T_W-1:0]   t3_reg  [INFLUENCES][AXES];
    logic signed [Q_W-1:0]   q3_reg  [INFLUENCES][AXES];
    logic signed [WGT_W-1:0] wt3_reg [INFLUENCES];

    // Stage 4: weighting
    logic                    v4_reg, last4_reg;
    logic signed [TW_W-1:0]  tw4_reg [INFLUENCES][AXES];
    logic signed [QW_W-1:0]  qw4_reg [INFLUENCES][AXES];

    // Stage 5: rounding
    logic                    v5_reg, last5_reg;
    logic signed [RT_W-1:0]  rt5_reg [INFLUENCES][AXES];
    logic signed [RQ_W-1:0]  rq5_reg [INFLUENCES][AXES];

    // Stage 6: accumulate over influences
    logic                     v6_reg, last6_reg;
    logic signed [ACCP_W-1:0] accp6_reg [AXES];
    logic signed [ACCN_W-1:0] accn6_reg [AXES];

    logic [POS_W-1:0]        me     [INFLUENCES][WORDS_PER_BONE];
    logic signed [T_W-1:0]   t_c    [INFLUENCES][AXES];
    logic signed [Q_W-1:0]   q_c    [INFLUENCES][AXES];
    logic signed [ACCP_W-1:0] ap_c  [AXES];
    logic signed [ACCN_W-1:0] an_c  [AXES];

    // Zero the words of skipped influences so unwritten entries never reach the sums
    always_comb begin
        for (int j = 0; j < INFLUENCES; j++) begin
            for (int e = 0; e < WORDS_PER_BONE; e++) begin
                me[j][e] = use1_reg[j] ? mq[j][e] : '0;
            end
        end
    end

    always_comb begin
        logic signed [T_W-1:0] ts;
        logic signed [T_W-1:0] ns;
        for (int j = 0; j < INFLUENCES; j++) begin
            for (int r = 0; r < AXES; r++) begin
                ts = T_W'(tr2_reg[j][r]);
                ns = '0;
                for (int c = 0; c < AXES; c++) begin
                    ts = ts + T_W'((pp2_reg[j][r][c] + PP_W'(64'sd32768)) >>> 16);
                    ns = ns + T_W'(pn2_reg[j][r][c]);
                end
                t_c[j][r] = ts;
                q_c[j][r] = Q_W'((ns + T_W'(64'sd8192)) >>> NSH);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            ap_c[r] = '0;
            an_c[r] = '0;
            for (int j = 0; j < INFLUENCES; j++) begin
                ap_c[r] = ap_c[r] + ACCP_W'(rt5_reg[j][r]);
                an_c[r] = an_c[r] + ACCN_W'(rq5_reg[j][r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= vtx_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last1_reg <= vtx_last;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
            last4_reg <= last3_reg;
            last5_reg <= last4_reg;
            last6_reg <= last5_reg;
            for (int r = 0; r < AXES; r++) begin
                pos1_reg[r] <= vtx_pos[r];
                nrm1_reg[r] <= vtx_nrm[r];
            end
            for (int j = 0; j < INFLUENCES; j++) begin
                use1_reg[j] <= usable[j];
                wt1_reg[j]  <= usable[j] ? $signed(wsel[j]) : '0;
                wt2_reg[j]  <= wt1_reg[j];
                wt3_reg[j]  <= wt2_reg[j];
                for (int r = 0; r < AXES; r++) begin
                    tr2_reg[j][r] <= $signed(me[j][9+r]);
                    for (int c = 0; c < AXES; c++) begin
                        pp2_reg[j][r][c] <= $signed(me[j][c*3+r]) * pos1_reg[c];
                        pn2_reg[j][r][c] <= $signed(me[j][c*3+r]) * nrm1_reg[c];
                    end
                    t3_reg[j][r]  <= t_c[j][r];
                    q3_reg[j][r]  <= q_c[j][r];
                    tw4_reg[j][r] <= t3_reg[j][r] * wt3_reg[j];
                    qw4_reg[j][r] <= q3_reg[j][r] * wt3_reg[j];
                    rt5_reg[j][r] <= RT_W'((tw4_reg[j][r] + TW_W'(64'sd16384)) >>> 15);
                    rq5_reg[j][r] <= RQ_W'((qw4_reg[j][r] + QW_W'(64'sd16384)) >>> 15);
                end
            end
            for (int r = 0; r < AXES; r++) begin
                accp6_reg[r] <= ap_c[r];
                accn6_reg[r] <= an_c[r];
            end
        end
    end

    assign out_ctl.valid = v6_reg;
    assign out_ctl.last  = last6_reg;
    assign accp          = accp6_reg;
    assign accn          = accn6_reg;

endmodule

>>> hw/rtl/lbs_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a
// sideband that travels alongside. Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_isqrt import lbs_pkg::*; #(
    parameter int SideW = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_sq,
    input  logic [SideW-1:0]  in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SideW-1:0]  out_side
);

    logic [SQRT_ACC_W-1:0] rem_reg  [SQRT_STEPS];
    logic [SQRT_ACC_W-1:0] root_reg [SQRT_STEPS];
    logic [SideW-1:0]      side_reg [SQRT_STEPS];
    logic                  vld_reg  [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        localparam logic [SQRT_ACC_W-1:0] BIT =
            SQRT_ACC_W'(1) << (2 * (SQRT_STEPS - 1 - i));
        logic [SQRT_ACC_W-1:0] rem_in, root_in, trial, rem_nx, root_nx;
        logic [SideW-1:0]      side_in;
        logic                  vld_in;

        if (i == 0) begin : g_head
            assign rem_in  = SQRT_ACC_W'(in_sq);
            assign root_in = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_body
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_in = side_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        always_comb begin
            trial = root_in + BIT;
            if (rem_in >= trial) begin
                rem_nx  = rem_in - trial;
                root_nx = (root_in >> 1) + BIT;
            end else begin
                rem_nx  = rem_in;
                root_nx = root_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_nx;
                root_reg[i] <= root_nx;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_root  = ROOT_W'(root_reg[SQRT_STEPS-1]);
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

>>> hw/rtl/lbs_div.sv
// Pipelined rounded division of several magnitudes by one shared length,
// one quotient bit per stage. Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_div import lbs_pkg::*; #(
    parameter int SideW = 1,
    parameter int Lanes = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] in_len,
    input  logic [NMAG_W-1:0] in_mag [Lanes],
    input  logic [SideW-1:0]  in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo [Lanes],
    output logic [SideW-1:0]  out_side
);

    logic [DIV_REM_W-1:0] rem_reg  [QUO_W+1][Lanes];
    logic [QUO_W-1:0]     quo_reg  [QUO_W+1][Lanes];
    logic [ROOT_W-1:0]    len_reg  [QUO_W+1];
    logic [SideW-1:0]     side_reg [QUO_W+1];
    logic                 vld_reg  [QUO_W+1];

    // Prep: dividend = mag * 2^14 + len / 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg[0]  <= in_len;
            side_reg[0] <= in_side;
            for (int l = 0; l < Lanes; l++) begin
                rem_reg[0][l] <= (DIV_REM_W'(in_mag[l]) << NSH) + DIV_REM_W'(in_len >> 1);
                quo_reg[0][l] <= '0;
            end
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int K = QUO_W - 1 - s;
        logic [DIV_REM_W-1:0] dsh;
        logic [DIV_REM_W-1:0] rem_nx [Lanes];
        logic [QUO_W-1:0]     quo_nx [Lanes];

        assign dsh = DIV_REM_W'(len_reg[s]) << K;

        always_comb begin
            for (int l = 0; l < Lanes; l++) begin
                if (rem_reg[s][l] >= dsh) begin
                    rem_nx[l] = rem_reg[s][l] - dsh;
                    quo_nx[l] = quo_reg[s][l] | (QUO_W'(1) << K);
                end else begin
                    rem_nx[l] = rem_reg[s][l];
                    quo_nx[l] = quo_reg[s][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (en) begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[s+1]  <= len_reg[s];
                side_reg[s+1] <= side_reg[s];
                for (int l = 0; l < Lanes; l++) begin
                    rem_reg[s+1][l] <= rem_nx[l];
                    quo_reg[s+1][l] <= quo_nx[l];
                end
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

>>> hw/rtl/linear_blend_skinning.sv
// Four-influence linear blend skinning: top level with APB register, clamp and
// normal scaling stages, output register. Depends on lbs_pkg, lbs_blend,
// lbs_isqrt and lbs_div.
//
// Usage: the s_ channel takes two kinds of item. A load item (s_kind = 0)
// writes one Q16.16 word of a bone's 3x4 matrix; it gives no result. A vertex
// item (s_kind = 1) gives exactly one result on the m_ channel: the blended
// position (saturated Q16.16) and the unit normal (Q2.14), with end_of_mesh
// copied from last_vertex. Load every bone a vertex uses before sending it.
// The user must write bones_in_use through the APB port at address 0 only while
// idle; the block itself does not enforce this. Throughput: one item per cycle
// while the receiver does not stall; the depth is set by the 32-stage square root
// and the 16-stage divider that scale the normal.
// Reset clears bones_in_use and all valid bits; matrix contents are kept.
// When the receiver stalls, the whole pipeline holds in place and s_ready
// drops, so nothing is lost or repeated.
`timescale 1ns / 1ps

module linear_blend_skinning import lbs_pkg::*; #(
    parameter int MAX_BONES  = MAX_BONES_DEF,
    parameter int INFLUENCES = INFLUENCES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic [SLOT_W-1:0]        s_matrix_slot,
    input  logic signed [POS_W-1:0]  s_matrix_value,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [POS_W-1:0]  s_pos_z,
    input  logic signed [NRM_W-1:0]  s_nrm_x,
    input  logic signed [NRM_W-1:0]  s_nrm_y,
    input  logic signed [NRM_W-1:0]  s_nrm_z,
    input  logic [MAX_INFL*BONE_W-1:0] s_influence_bones,
    input  logic [MAX_INFL*WGT_W-1:0]  s_influence_weights,
    input  logic                     s_last_vertex,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [POS_W-1:0]  m_out_pos_x,
    output logic signed [POS_W-1:0]  m_out_pos_y,
    output logic signed [POS_W-1:0]  m_out_pos_z,
    output logic signed [NRM_W-1:0]  m_out_nrm_x,
    output logic signed [NRM_W-1:0]  m_out_nrm_y,
    output logic signed [NRM_W-1:0]  m_out_nrm_z,
    output logic                     m_end_of_mesh
);

    localparam int ISQ_SIDE_W = AXES*POS_W + AXES*NMAG_W + AXES + 2;
    localparam int DIV_SIDE_W = AXES*POS_W + AXES + 2;

    logic en;

    // Configuration register
    logic [CFG_W-1:0] bones_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bones_reg <= '0;
        end else if (psel && penable && pwrite && (paddr == ADDR_BONES_IN_USE)) begin
            bones_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BONES_IN_USE) ? PDATA_W'(bones_reg) : '0;

    // Advance everything unless the output register holds an untaken result
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic signed [POS_W-1:0] vtx_pos [AXES];
    logic signed [NRM_W-1:0] vtx_nrm [AXES];
    assign vtx_pos = '{s_pos_x, s_pos_y, s_pos_z};
    assign vtx_nrm = '{s_nrm_x, s_nrm_y, s_nrm_z};

    beat_ctl_t                b_ctl;
    logic signed [ACCP_W-1:0] b_accp [AXES];
    logic signed [ACCN_W-1:0] b_accn [AXES];

    lbs_blend #(.MAX_BONES(MAX_BONES), .INFLUENCES(INFLUENCES)) u_blend (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .ld_we        (s_valid && en && !s_kind),
        .ld_slot      (s_matrix_slot),
        .ld_value     (s_matrix_value),
        .vtx_valid    (s_valid && en && s_kind),
        .vtx_pos      (vtx_pos),
        .vtx_nrm      (vtx_nrm),
        .vtx_bones    (s_influence_bones),
        .vtx_weights  (s_influence_weights),
        .vtx_last     (s_last_vertex),
        .bones_in_use (bones_reg),
        .out_ctl      (b_ctl),
        .accp         (b_accp),
        .accn         (b_accn)
    );

    // Stage 7: clamp position, split normal into sign and magnitude
    // Stage 8: largest magnitude; stage 9: its top bit; stage 10: scale
    // Stage 11: squares; stage 12: sum of squares
    logic                    v_reg   [7:12];
    logic                    last_reg[7:12];
    logic signed [POS_W-1:0] pos_reg [7:12][AXES];
    logic [MAG_W-1:0]        mag_reg [7:9][AXES];
    logic [AXES-1:0]         neg_reg [7:12];
    logic [MAG_W-1:0]        mx8_reg;
    logic [HI_W-1:0]         hi9_reg;
    logic                    nz_reg  [9:12];
    logic [NMAG_W-1:0]       nmag_reg[10:12][AXES];
    logic [SQP_W-1:0]        sqp11_reg [AXES];
    logic [SQ_W-1:0]         sq12_reg;

    logic signed [POS_W-1:0] clamp_c [AXES];
    logic [MAG_W-1:0]        mag_c   [AXES];
    logic [MAG_W-1:0]        mx_c;
    logic [HI_W-1:0]         hi_c;
    logic [NMAG_W-1:0]       nmag_c  [AXES];

    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            if (b_accp[r] > POS_MAX) begin
                clamp_c[r] = POS_W'(POS_MAX);
            end else if (b_accp[r] < POS_MIN) begin
                clamp_c[r] = POS_W'(POS_MIN);
            end else begin
                clamp_c[r] = POS_W'(b_accp[r]);
            end
            mag_c[r] = b_accn[r][ACCN_W-1] ? MAG_W'(-b_accn[r]) : MAG_W'(b_accn[r]);
        end
    end

    always_comb begin
        mx_c = mag_reg[7][0];
        for (int r = 1; r < AXES; r++) begin
            if (mag_reg[7][r] > mx_c) begin
                mx_c = mag_reg[7][r];
            end
        end
    end

    always_comb begin
        hi_c = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mx8_reg[b]) begin
                hi_c = HI_W'(b);
            end
        end
    end

    // Bring the largest magnitude into [2^28, 2^30), truncating on a right shift
    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            if (hi9_reg >= HI_W'(30)) begin
                nmag_c[r] = NMAG_W'(mag_reg[9][r] >> (hi9_reg - HI_W'(29)));
            end else if (hi9_reg < HI_W'(28)) begin
                nmag_c[r] = NMAG_W'(mag_reg[9][r] << (HI_W'(28) - hi9_reg));
            end else begin
                nmag_c[r] = NMAG_W'(mag_reg[9][r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 7; s <= 12; s++) begin
                v_reg[s] <= 1'b0;
            end
        end else if (en) begin
            v_reg[7] <= b_ctl.valid;
            for (int s = 8; s <= 12; s++) begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg[7] <= b_ctl.last;
            for (int s = 8; s <= 12; s++) begin
                last_reg[s] <= last_reg[s-1];
                pos_reg[s]  <= pos_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
            end
            for (int r = 0; r < AXES; r++) begin
                pos_reg[7][r] <= clamp_c[r];
                mag_reg[7][r] <= mag_c[r];
                neg_reg[7][r] <= b_accn[r][ACCN_W-1];
            end
            mag_reg[8] <= mag_reg[7];
            mag_reg[9] <= mag_reg[8];
            mx8_reg    <= mx_c;
            hi9_reg    <= hi_c;
            nz_reg[9]  <= (mx8_reg != '0);
            nz_reg[10] <= nz_reg[9];
            nz_reg[11] <= nz_reg[10];
            nz_reg[12] <= nz_reg[11];
            nmag_reg[10] <= nmag_c;
            nmag_reg[11] <= nmag_reg[10];
            nmag_reg[12] <= nmag_reg[11];
            for (int r = 0; r < AXES; r++) begin
                sqp11_reg[r] <= SQP_W'(nmag_reg[10][r]) * SQP_W'(nmag_reg[10][r]);
            end
            sq12_reg <= SQ_W'(sqp11_reg[0]) + SQ_W'(sqp11_reg[1]) + SQ_W'(sqp11_reg[2]);
        end
    end

    // Square root of the sum of squares
    logic [ISQ_SIDE_W-1:0] isq_side_in, isq_side_out;
    logic                  isq_valid;
    logic [ROOT_W-1:0]     isq_root;

    assign isq_side_in = {pos_reg[12][0], pos_reg[12][1], pos_reg[12][2],
                          nmag_reg[12][0], nmag_reg[12][1], nmag_reg[12][2],
                          neg_reg[12], nz_reg[12], last_reg[12]};

    lbs_isqrt #(.SideW(ISQ_SIDE_W)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_reg[12]),
        .in_sq     (sq12_reg),
        .in_side   (isq_side_in),
        .out_valid (isq_valid),
        .out_root  (isq_root),
        .out_side  (isq_side_out)
    );

    logic signed [POS_W-1:0] q_pos  [AXES];
    logic [NMAG_W-1:0]       q_nmag [AXES];
    logic [AXES-1:0]         q_neg;
    logic                    q_nz, q_last;

    assign {q_pos[0], q_pos[1], q_pos[2], q_nmag[0], q_nmag[1], q_nmag[2],
            q_neg, q_nz, q_last} = isq_side_out;

    // Rounded division of each magnitude by the length
    logic [DIV_SIDE_W-1:0] div_side_in, div_side_out;
    logic                  div_valid;
    logic [QUO_W-1:0]      div_quo [AXES];

    assign div_side_in = {q_pos[0], q_pos[1], q_pos[2], q_neg, q_nz, q_last};

    lbs_div #(.SideW(DIV_SIDE_W), .Lanes(AXES)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (isq_valid),
        .in_len    (isq_root),
        .in_mag    (q_nmag),
        .in_side   (div_side_in),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side_out)
    );

    logic signed [POS_W-1:0] d_pos [AXES];
    logic [AXES-1:0]         d_neg;
    logic                    d_nz, d_last;
    logic signed [NRM_W-1:0] nrm_c [AXES];

    assign {d_pos[0], d_pos[1], d_pos[2], d_neg, d_nz, d_last} = div_side_out;

    // A zero-length normal stays zero
    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            if (!d_nz) begin
                nrm_c[r] = '0;
            end else if (d_neg[r]) begin
                nrm_c[r] = -NRM_W'(div_quo[r]);
            end else begin
                nrm_c[r] = NRM_W'(div_quo[r]);
            end
        end
    end

    // Output register
    logic signed [POS_W-1:0] opos_reg [AXES];
    logic signed [NRM_W-1:0] onrm_reg [AXES];
    logic                    olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            opos_reg  <= d_pos;
            onrm_reg  <= nrm_c;
            olast_reg <= d_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_pos_x   = opos_reg[0];
    assign m_out_pos_y   = opos_reg[1];
    assign m_out_pos_z   = opos_reg[2];
    assign m_out_nrm_x   = onrm_reg[0];
    assign m_out_nrm_y   = onrm_reg[1];
    assign m_out_nrm_z   = onrm_reg[2];
    assign m_end_of_mesh = olast_reg;

    a_nrm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_nrm_x <= 16'sd16384) && (m_out_nrm_x >= -16'sd16384) &&
                    (m_out_nrm_y <= 16'sd16384) && (m_out_nrm_y >= -16'sd16384) &&
                    (m_out_nrm_z <= 16'sd16384) && (m_out_nrm_z >= -16'sd16384))
        else $error("normal component outside unit range");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && (paddr == ADDR_BONES_IN_USE))
        |=> (bones_reg == $past(pwdata[CFG_W-1:0])))
        else $error("bones_in_use write lost");

    a_stall_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while output stalled");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for linear_blend_skinning: directed rows, then random
// load and vertex traffic checked against a fixed-point skinning predictor.
// Depends on lbs_pkg and the linear_blend_skinning RTL.
`timescale 1ns / 1ps

module tb_top;
    import lbs_pkg::*;

    localparam int N_BONES    = 64;
    localparam int N_WORDS    = N_BONES * WORDS_PER_BONE;
    localparam int DRAIN_CYC  = 80;
    localparam int HOLD_CYC   = 400;
    localparam int IDLE_LIMIT = 5000;
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef struct {
        logic        kind;
        logic [9:0]  slot;
        logic [31:0] value;
        logic [31:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic [31:0] bones;
        logic [63:0] weights;
        logic        last;
    } item_t;

    typedef struct {
        logic [31:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic        eom;
    } skin_t;

    typedef struct {
        item_t it;
        logic  typed;
        skin_t res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = 1'b0;
    logic [SLOT_W-1:0] s_matrix_slot = '0;
    logic signed [POS_W-1:0] s_matrix_value = '0;
    logic signed [POS_W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [NRM_W-1:0] s_nrm_x = '0, s_nrm_y = '0, s_nrm_z = '0;
    logic [MAX_INFL*BONE_W-1:0] s_influence_bones = '0;
    logic [MAX_INFL*WGT_W-1:0] s_influence_weights = '0;
    logic s_last_vertex = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [POS_W-1:0] m_out_pos_x, m_out_pos_y, m_out_pos_z;
    logic signed [NRM_W-1:0] m_out_nrm_x, m_out_nrm_y, m_out_nrm_z;
    logic m_end_of_mesh;

    int          bone_words [N_WORDS];
    bit          word_loaded [N_WORDS];
    int unsigned bones_limit;
    skin_t       skinned_q [$];
    int          errors = 0;
    bit          hold_req = 1'b0;
    int          send_calm = 0;

    always #4 aclk = ~aclk;

    linear_blend_skinning dut (.*);

    task automatic report(string what, longint got, longint want);
        errors++;
        if (errors <= 60)
            $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    function automatic longint rnd(longint x, int k);
        return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bw = 64'h4000_0000_0000_0000;
        while (bw > v) bw >>= 2;
        while (bw != 0) begin
            if (v >= res + bw) begin
                v -= res + bw;
                res = (res >> 1) + bw;
            end else begin
                res >>= 1;
            end
            bw >>= 2;
        end
        return res;
    endfunction

    function automatic int unsigned eff_limit();
        return bones_limit > N_BONES ? N_BONES : bones_limit;
    endfunction

    function automatic skin_t skin_predict(item_t s);
        longint p[3], n[3], m[12];
        longint accp[3] = '{0, 0, 0};
        longint accn[3] = '{0, 0, 0};
        longint t, q, w, v, o;
        longint unsigned mag[3], mx, sq, len;
        logic [31:0] opos[3];
        logic [15:0] onrm[3];
        int b;
        skin_t res;
        p[0] = longint'($signed(s.px));
        p[1] = longint'($signed(s.py));
        p[2] = longint'($signed(s.pz));
        n[0] = longint'($signed(s.nx));
        n[1] = longint'($signed(s.ny));
        n[2] = longint'($signed(s.nz));
        for (int j = 0; j < MAX_INFL; j++) begin
            b = s.bones[8*j +: 8];
            w = longint'($signed(s.weights[16*j +: 16]));
            if (w <= 0 || b >= eff_limit())
                continue;
            for (int e = 0; e < WORDS_PER_BONE; e++)
                m[e] = longint'(bone_words[b*WORDS_PER_BONE + e]);
            for (int r = 0; r < 3; r++) begin
                t = rnd(m[r] * p[0], 16) + rnd(m[3+r] * p[1], 16)
                    + rnd(m[6+r] * p[2], 16) + m[9+r];
                q = rnd(m[r] * n[0] + m[3+r] * n[1] + m[6+r] * n[2], 14);
                accp[r] += rnd(t * w, 15);
                accn[r] += rnd(q * w, 15);
            end
        end
        mx = 0;
        for (int r = 0; r < 3; r++) begin
            v = accp[r];
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            opos[r] = v[31:0];
            mag[r] = accn[r] < 0 ? -accn[r] : accn[r];
            if (mag[r] > mx) mx = mag[r];
        end
        if (mx == 0) begin
            onrm = '{16'h0, 16'h0, 16'h0};
        end else begin
            while (mx >= (64'd1 << 30)) begin
                mx >>= 1;
                for (int r = 0; r < 3; r++) mag[r] >>= 1;
            end
            while (mx < (64'd1 << 28)) begin
                mx <<= 1;
                for (int r = 0; r < 3; r++) mag[r] <<= 1;
            end
            sq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
            len = root64(sq);
            for (int r = 0; r < 3; r++) begin
                o = longint'((mag[r] * 16384 + len / 2) / len);
                if (accn[r] < 0) o = -o;
                onrm[r] = o[15:0];
            end
        end
        res = '{opos[0], opos[1], opos[2], onrm[0], onrm[1], onrm[2], s.last};
        return res;
    endfunction

    function automatic bit bone_ready(int b);
        for (int e = 0; e < WORDS_PER_BONE; e++)
            if (!word_loaded[b*WORDS_PER_BONE + e]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic item_t mk_load(int slot, logic [31:0] val);
        item_t it = '{default: '0};
        it.kind = KIND_LOAD;
        it.slot = slot[9:0];
        it.value = val;
        return it;
    endfunction

    function automatic item_t mk_vtx(logic [31:0] px, py, pz, logic [15:0] nx, ny, nz,
                                     logic [31:0] bones, logic [63:0] weights, logic last);
        item_t it = '{default: '0};
        it.kind = KIND_VERTEX;
        {it.px, it.py, it.pz} = {px, py, pz};
        {it.nx, it.ny, it.nz} = {nx, ny, nz};
        it.bones = bones;
        it.weights = weights;
        it.last = last;
        return it;
    endfunction

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Apply a transfer to the predictor state and queue what it should produce.
    task automatic accept_item(item_t it, logic typed, skin_t res);
        if (it.kind == KIND_LOAD) begin
            if (it.slot < N_WORDS) begin
                bone_words[it.slot] = int'(it.value);
                word_loaded[it.slot] = 1'b1;
            end
        end else begin
            skinned_q.push_back(typed ? res : skin_predict(it));
        end
    endtask

    task automatic send(item_t it, logic typed = 1'b0, skin_t res = '{default: '0});
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 59) == 0) send_calm = 30;
            gap = pick_gap();
        end
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_matrix_slot <= it.slot;
        s_matrix_value <= it.value;
        s_pos_x <= it.px;
        s_pos_y <= it.py;
        s_pos_z <= it.pz;
        s_nrm_x <= it.nx;
        s_nrm_y <= it.ny;
        s_nrm_z <= it.nz;
        s_influence_bones <= it.bones;
        s_influence_weights <= it.weights;
        s_last_vertex <= it.last;
        do @(posedge aclk); while (!s_ready);
        accept_item(it, typed, res);
    endtask

    // Drop valid and wait until every queued result has come out.
    task automatic drain();
        @(negedge aclk) s_valid <= 1'b0;
        while (skinned_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_bones_in_use(int unsigned val);
        drain();
        repeat (DRAIN_CYC) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_BONES_IN_USE;
        pwdata <= PDATA_W'(val);
        @(negedge aclk) penable <= 1'b1;
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk) penable <= 1'b1;
        @(posedge aclk);
        if (prdata[CFG_W-1:0] != val[CFG_W-1:0])
            report("bones_in_use readback", prdata[CFG_W-1:0], val[CFG_W-1:0]);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        bones_limit = val & 7'h7F;
    endtask

    function automatic logic [31:0] rand_word();
        int r = $urandom_range(0, 3);
        if (r == 0) return $urandom;
        if (r == 1) return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
        return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
    endfunction

    task automatic load_bone(int b, bit random_vals);
        logic [31:0] val;
        for (int e = 0; e < WORDS_PER_BONE; e++) begin
            if (random_vals)
                val = rand_word();
            else if (b == 0)
                val = (e == 0 || e == 4 || e == 8) ? 32'h10000 : (e >= 9 ? (e - 8) << 16 : 0);
            else
                val = 32'h7FFF_FFFF;
            send(mk_load(b*WORDS_PER_BONE + e, val));
        end
    endtask

    function automatic item_t rand_vertex();
        logic [31:0] pos[3], bones;
        logic [15:0] nrm[3], w;
        logic [63:0] weights;
        int b;
        for (int r = 0; r < 3; r++) begin
            pos[r] = $urandom_range(0, 3) == 0 ? 32'($urandom)
                                               : 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
            nrm[r] = $urandom_range(0, 1) ? 16'($urandom)
                                          : 16'($urandom_range(0, 1 << 15)) - 16'(1 << 14);
        end
        for (int j = 0; j < MAX_INFL; j++) begin
            case ($urandom_range(0, 9))
                0: b = $urandom_range(N_BONES, 255);
                1, 2: b = $urandom_range(0, N_BONES - 1);
                default: begin
                    b = $urandom_range(0, N_BONES - 1);
                    for (int k = 0; k < N_BONES && !bone_ready(b); k++)
                        b = (b + 1) % N_BONES;
                end
            endcase
            case ($urandom_range(0, 7))
                0: w = 16'h0;
                1: w = 16'h8000 | 16'($urandom);
                2: w = 16'h7FFF;
                default: w = 16'($urandom_range(1, 16'h7FFF));
            endcase
            // Never let a live influence read a bone that is not fully loaded.
            if (!w[15] && w != 0 && b < eff_limit() && !bone_ready(b))
                w = 16'h0;
            bones[8*j +: 8] = b[7:0];
            weights[16*j +: 16] = w;
        end
        return mk_vtx(pos[0], pos[1], pos[2], nrm[0], nrm[1], nrm[2], bones, weights,
                      $urandom_range(0, 7) == 0);
    endfunction

    // Result channel: random backpressure, with one long hold-off on request.
    initial begin
        int stall_left = 0;
        int calm_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYC;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 70) begin
                if ($urandom_range(0, 49) == 0) calm_left = 40;
                m_ready <= 1'b1;
            end else begin
                stall_left = $urandom_range(0, 9) == 0 ? $urandom_range(15, 60)
                                                       : $urandom_range(0, 3);
                m_ready <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        skin_t want;
        if (aresetn && m_valid && m_ready) begin
            if (skinned_q.size() == 0) begin
                report("unexpected result", m_out_pos_x, 0);
            end else begin
                want = skinned_q.pop_front();
                if (m_out_pos_x !== want.px) report("out_pos_x", m_out_pos_x, want.px);
                if (m_out_pos_y !== want.py) report("out_pos_y", m_out_pos_y, want.py);
                if (m_out_pos_z !== want.pz) report("out_pos_z", m_out_pos_z, want.pz);
                if (m_out_nrm_x !== want.nx) report("out_nrm_x", m_out_nrm_x, want.nx);
                if (m_out_nrm_y !== want.ny) report("out_nrm_y", m_out_nrm_y, want.ny);
                if (m_out_nrm_z !== want.nz) report("out_nrm_z", m_out_nrm_z, want.nz);
                if (m_end_of_mesh !== want.eom)
                    report("end_of_mesh", m_end_of_mesh, want.eom);
            end
        end
    end

    always @(posedge aclk) begin
        int idle_cyc;
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        row_t dir_rows [$];
        skin_t zero_eom = '{default: '0};
        skin_t zero_mid = '{default: '0};
        int unsigned phase_cfg [6] = '{64, 127, 37, 1, 0, 64};
        int phase_items [6] = '{150, 150, 150, 120, 40, 150};
        zero_eom.eom = 1'b1;
        bones_limit = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // With no bones in use every vertex blends to zero.
        set_bones_in_use(0);
        send(mk_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000,
                    16'hFFFF, 32'h0302_0100, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1), 1'b1, zero_eom);
        send(mk_vtx(0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, zero_mid);

        load_bone(0, 1'b0);
        load_bone(1, 1'b1);
        load_bone(2, 1'b1);
        load_bone(3, 1'b1);
        load_bone(63, 1'b0);
        set_bones_in_use(64);

        dir_rows = '{
            '{mk_load(1023, 32'hFFFF_FFFF), 1'b0, zero_mid},
            '{mk_load(768, 32'h1234_5678), 1'b0, zero_mid},
            '{mk_vtx(32'h1_0000, 32'h2_0000, 32'h3_0000, 16'h4000, 0, 0,
                     32'h0302_0100, 64'h7FFF, 1'b0), 1'b0, zero_mid},
            '{mk_vtx(32'h1_8000, 32'hFFFE_0000, 32'h0, 16'h2000, 16'h2000, 16'hE000,
                     32'h0302_0100, 64'h2000_2000_2000_2000, 1'b1), 1'b0, zero_mid},
            '{mk_vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF,
                     16'h7FFF, 32'h3F3F_3F3F, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0), 1'b0, zero_mid},
            '{mk_vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
                     16'h8000, 32'h3F3F_3F3F, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1), 1'b0, zero_mid},
            '{mk_vtx(32'h5_0000, 32'h6_0000, 32'h7_0000, 0, 0, 0,
                     32'h0000_0000, 64'h7FFF, 1'b0), 1'b0, zero_mid},
            '{mk_vtx(32'h5_0000, 32'h6_0000, 32'h7_0000, 16'h4000, 0, 0,
                     32'h0302_0100, 64'h8000_8001_FFFF_8000, 1'b1), 1'b1, zero_eom},
            '{mk_vtx(32'h5_0000, 32'h6_0000, 32'h7_0000, 16'h4000, 0, 0,
                     32'hFFC8_4140, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0), 1'b1, zero_mid},
            '{mk_vtx(32'h1, 32'hFFFF_FFFF, 32'h0, 16'h0001, 16'hFFFF, 16'h0,
                     32'h4001_0203, 64'h7FFF_1000_8000_0001, 1'b0), 1'b0, zero_mid},
            '{mk_vtx(32'h0, 32'h0, 32'h0, 16'h8000, 16'h7FFF, 16'h0,
                     32'h0203_3F00, 64'h0001_0001_7FFF_4000, 1'b1), 1'b0, zero_mid}
        };
        foreach (dir_rows[i])
            send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

        for (int ph = 0; ph < 6; ph++) begin
            set_bones_in_use(phase_cfg[ph]);
            for (int i = 0; i < phase_items[ph]; i++) begin
                if (ph == 1 && i == 40) hold_req = 1'b1;
                if (ph == 3 && i == 60) drain();
                case ($urandom_range(0, 11))
                    0: begin
                        load_bone($urandom_range(0, N_BONES - 1), 1'b1);
                        i += WORDS_PER_BONE - 1;
                    end
                    1: send(mk_load($urandom_range(0, 1023), rand_word()));
                    default: send(rand_vertex());
                endcase
            end
        end

        drain();
        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_ram.sv
hw/rtl/lbs_blend.sv
hw/rtl/lbs_isqrt.sv
hw/rtl/lbs_div.sv
hw/rtl/linear_blend_skinning.sv
test/tb_top.sv
